// File: src/rcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcr_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int SLOT_W  = 8;
   localparam int COLOR_W = 15;
   localparam int CSR_W   = 4;

   localparam logic [0:0] CSR_REDUCE_MODE  = 1'd0;
   localparam logic [0:0] CSR_PALETTE_BANK = 1'd1;

   localparam logic [2:0] MODE_LEARN_255 = 3'd0;
   localparam logic [2:0] MODE_LEARN_223 = 3'd1;
   localparam logic [2:0] MODE_FIXED_15  = 3'd2;
   localparam logic [2:0] MODE_GRAY_15   = 3'd3;
   localparam logic [2:0] MODE_GRAY_32   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // probe that walks the cell row
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [COLOR_W-1:0] color;
      logic [SLOT_W-1:0]  slot;
   } probe_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [SLOT_W-1:0]  limit;
      logic [SLOT_W-1:0]  count;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_slot;
      logic [COLOR_W-1:0] wr_color;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: src/rcr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rcr_cell #(
   parameter int SLOT = 1
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rcr_pkg::cell_ctl_type ctl,
   input  rcr_pkg::probe_type   probe_i,
   output rcr_pkg::probe_type   probe_o
);
   import rcr_pkg::*;

   localparam logic [SLOT_W-1:0] SLOT_V = SLOT_W'(SLOT);

   logic [COLOR_W-1:0] entry_ff;
   logic [COLOR_W-1:0] entry_in;
   probe_type          probe_ff;
   probe_type          probe_in;
   logic               active;
   logic               match;

   always_comb begin
      // slot takes part only inside the current limit and fill
      active   = (SLOT_V < ctl.limit) && (SLOT_V <= ctl.count);
      match    = probe_i.valid && active && (entry_ff == probe_i.color);
      probe_in = probe_i;
      if (!probe_i.hit && match) begin
         probe_in.hit  = 1'b1;
         probe_in.slot = SLOT_V;
      end
      entry_in = entry_ff;
      if (ctl.wr_en && (ctl.wr_slot == SLOT_V)) begin
         entry_in = ctl.wr_color;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign probe_o = probe_ff;

endmodule

`default_nettype wire

// File: src/rcr_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module rcr_chain #(
   parameter int CELLS = 255
) (
   input  wire                   clock,
   input  wire                   reset,
   input  rcr_pkg::cell_ctl_type ctl,
   input  rcr_pkg::probe_type    head,
   output rcr_pkg::probe_type    tail
);
   import rcr_pkg::*;

   probe_type link [0:CELLS];

   assign link[0] = head;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      rcr_cell #(
         .SLOT(k + 1)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .probe_i(link[k]),
         .probe_o(link[k+1])
      );
   end

   assign tail = link[CELLS];

endmodule

`default_nettype wire

// File: src/rgb555_color_reducer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB555 to palette index reducer. One result per accepted pixel, in order.
// Transparent pixels and the fixed-color and gray modes go from evaluation straight to finish.
// In the learned-palette modes the reduced color is sent as a probe down a row
// of PALETTE_ENTRIES-1 cells, one learned slot per cell, one cell per cycle;
// the probe must reach the end of the row before the item is finished. A new
// item is taken while the previous result still waits in the output register.
module rgb555_color_reducer_unit #(
   parameter int PALETTE_ENTRIES = rcr_pkg::PALETTE_ENTRIES_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_write,
   input  wire  [0:0]                 csr_index,
   input  wire  [rcr_pkg::CSR_W-1:0]  csr_data,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [15:0]                req_pixel_color,
   input  wire                        req_start_of_image,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [8:0]                 rsp_pixel_index,
   output logic                       rsp_palette_write,
   output logic [rcr_pkg::SLOT_W-1:0] rsp_palette_slot,
   output logic [rcr_pkg::COLOR_W-1:0] rsp_palette_color,
   output logic                       rsp_table_full
);
   import rcr_pkg::*;

   localparam int CELLS = PALETTE_ENTRIES - 1;
   localparam logic [SLOT_W-1:0] LIMIT_255 = SLOT_W'((CELLS < 255) ? CELLS : 255);
   localparam logic [SLOT_W-1:0] LIMIT_223 = SLOT_W'((CELLS < 223) ? CELLS : 223);

   function automatic logic [4:0] reduce_channel(input logic [4:0] c);
      logic [5:0] v;
      v = {1'b0, c};
      if (c[1:0] != 2'd0) v = {1'b0, c & 5'h1c} + 6'd4;
      if (v < 6'd6) v = 6'd6;
      if (v > 6'd30) v = 6'd30;
      return v[4:0];
   endfunction

   function automatic logic [3:0] fixed_color(input logic [4:0] r, input logic [4:0] g,
                                              input logic [4:0] b);
      localparam logic [4:0] DARK   = 5'd11;
      localparam logic [4:0] BRIGHT = 5'd20;
      localparam logic [4:0] MID    = 5'd15;
      logic [3:0] res;
      if (r <= DARK && g < DARK && b < DARK) res = 4'd1;
      else if (r >= BRIGHT && g >= BRIGHT && b >= BRIGHT) res = 4'd2;
      else if (r >= BRIGHT && g >= BRIGHT) res = (b >= MID) ? 4'd2 : 4'd7;
      else if (r >= BRIGHT && b >= BRIGHT) res = (g >= MID) ? 4'd2 : 4'd8;
      else if (g >= BRIGHT && b >= BRIGHT) res = (r >= MID) ? 4'd2 : 4'd9;
      else if (r >= BRIGHT) begin
         if (g > DARK && b > DARK) res = (g < b) ? 4'd8 : 4'd7;
         else if (g > DARK) res = 4'd10;
         else if (b > DARK) res = 4'd13;
         else res = 4'd4;
      end else if (g >= BRIGHT) begin
         if (r > DARK && b > DARK) res = (r < b) ? 4'd9 : 4'd7;
         else if (r > DARK) res = 4'd11;
         else if (b > DARK) res = 4'd14;
         else res = 4'd5;
      end else if (b >= BRIGHT) begin
         if (r > DARK && g > DARK) res = (r < g) ? 4'd9 : 4'd8;
         else if (g > DARK) res = 4'd12;
         else if (r > DARK) res = 4'd15;
         else res = 4'd6;
      end else res = 4'd3;
      return res;
   endfunction

   state_type          state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   logic [3:0]         bank_ff, bank_in;
   logic [SLOT_W-1:0]  count_ff, count_in;
   logic [15:0]        pix_ff, pix_in;
   logic [COLOR_W-1:0] pd_ff, pd_in;

   logic [8:0]         res_index_ff, res_index_in;
   logic               res_write_ff, res_write_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [COLOR_W-1:0] res_color_ff, res_color_in;
   logic               res_full_ff, res_full_in;

   logic               out_valid_ff, out_valid_in;
   logic [8:0]         out_index_ff, out_index_in;
   logic               out_write_ff, out_write_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic               out_full_ff, out_full_in;

   cell_ctl_type       ctl;
   probe_type          head;
   probe_type          tail;

   logic               accept;
   logic               out_free;
   logic [4:0]         ch_r, ch_g, ch_b;
   logic [COLOR_W-1:0] pd;
   logic [8:0]         base;
   logic [6:0]         sum;
   logic [13:0]        sum_scaled;
   logic [4:0]         third;
   logic [4:0]         gray_even;
   logic [SLOT_W-1:0]  limit;
   logic [SLOT_W:0]    count_next;

   rcr_chain #(
      .CELLS(CELLS)
   ) u_chain (
      .clock(clock),
      .reset(reset),
      .ctl  (ctl),
      .head (head),
      .tail (tail)
   );

   always_comb begin
      accept   = req_valid && !req_stall;
      out_free = !out_valid_ff || !rsp_stall;

      ch_r = pix_ff[4:0];
      ch_g = pix_ff[9:5];
      ch_b = pix_ff[14:10];
      pd   = {reduce_channel(ch_b), reduce_channel(ch_g), reduce_channel(ch_r)};
      base = {1'b0, bank_ff, 4'd0};
      sum  = 7'(ch_r) + 7'(ch_g) + 7'(ch_b);
      // divide by 3 via reciprocal, exact for sums up to 93
      sum_scaled = 14'(sum) * 14'd171;
      third      = sum_scaled[13:9];
      gray_even  = third & 5'h1e;
      limit      = (mode_ff == MODE_LEARN_255) ? LIMIT_255 : LIMIT_223;
      count_next = {1'b0, count_ff} + 9'd1;

      state_in = state_ff;
      mode_in  = mode_ff;
      bank_in  = bank_ff;
      count_in = count_ff;
      pix_in   = pix_ff;
      pd_in    = pd_ff;

      res_index_in = res_index_ff;
      res_write_in = res_write_ff;
      res_slot_in  = res_slot_ff;
      res_color_in = res_color_ff;
      res_full_in  = res_full_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_write_in = out_write_ff;
      out_slot_in  = out_slot_ff;
      out_color_in = out_color_ff;
      out_full_in  = out_full_ff;

      head          = '0;
      ctl.limit     = limit;
      ctl.count     = count_ff;
      ctl.wr_en     = 1'b0;
      ctl.wr_slot   = count_next[SLOT_W-1:0];
      ctl.wr_color  = pd_ff;

      req_stall = (state_ff != ST_IDLE);

      if (csr_write) begin
         case (csr_index)
            CSR_REDUCE_MODE:  mode_in = csr_data[2:0];
            CSR_PALETTE_BANK: bank_in = csr_data[3:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in   = req_pixel_color;
               state_in = ST_EVAL;
               if (req_start_of_image) count_in = '0;
            end
         end
         ST_EVAL: begin
            res_index_in = base;
            res_write_in = 1'b0;
            res_slot_in  = '0;
            res_color_in = '0;
            res_full_in  = 1'b0;
            state_in     = ST_FINISH;
            if (!pix_ff[15]) begin
               case (mode_ff)
                  MODE_LEARN_255, MODE_LEARN_223: begin
                     pd_in      = pd;
                     head.valid = 1'b1;
                     head.color = pd;
                     state_in   = ST_SEARCH;
                  end
                  MODE_FIXED_15: res_index_in = base + 9'(fixed_color(ch_r, ch_g, ch_b));
                  MODE_GRAY_15: begin
                     if (gray_even == 5'd0) res_index_in = base + 9'd1;
                     else res_index_in = base + 9'(gray_even[4:1]);
                  end
                  MODE_GRAY_32: res_index_in = base + 9'd1 + 9'(third);
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (tail.valid) begin
               state_in = ST_FINISH;
               if (tail.hit) begin
                  res_index_in = base + 9'(tail.slot);
               end else if (count_next < {1'b0, limit}) begin
                  ctl.wr_en    = 1'b1;
                  count_in     = count_next[SLOT_W-1:0];
                  res_index_in = base + count_next;
                  res_write_in = 1'b1;
                  res_slot_in  = count_next[SLOT_W-1:0];
                  res_color_in = pd_ff;
               end else begin
                  res_index_in = base + 9'(limit);
                  res_full_in  = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = res_index_ff;
               out_write_in = res_write_ff;
               out_slot_in  = res_slot_ff;
               out_color_in = res_color_ff;
               out_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      pd_ff        <= pd_in;
      res_index_ff <= res_index_in;
      res_write_ff <= res_write_in;
      res_slot_ff  <= res_slot_in;
      res_color_ff <= res_color_in;
      res_full_ff  <= res_full_in;
      out_index_ff <= out_index_in;
      out_write_ff <= out_write_in;
      out_slot_ff  <= out_slot_in;
      out_color_ff <= out_color_in;
      out_full_ff  <= out_full_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_LEARN_255;
         bank_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_index   = out_index_ff;
   assign rsp_palette_write = out_write_ff;
   assign rsp_palette_slot  = out_slot_ff;
   assign rsp_palette_color = out_color_ff;
   assign rsp_table_full    = out_full_ff;

`ifndef ASSERT_OFF
   // the probe only reaches the end of the row while a search is waiting for it
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == ST_SEARCH))
      else $error("probe left the cell row outside a search");

   // fill never passes the last learned slot of the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < SLOT_W'(CELLS))
      else $error("learned palette fill past the row");

   // an item that appends cannot also overflow
   a_write_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_palette_write && rsp_table_full))
      else $error("append and overflow on the same item");

   // an append is recorded in the fill count on the next cycle
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> (count_ff == $past(count_next[SLOT_W-1:0])))
      else $error("fill count missed an append");
`endif

endmodule

`default_nettype wire
